@@ rtl/eqhor_pkg.sv @@
package eqhor_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int SQRT_STEPS    = 31;
	localparam int ROT_W         = 34;
	localparam int VEC_W         = 36;
	localparam int ANG_W         = 34;
	localparam int RAD_W         = 61;
	localparam int ROOT_W        = 63;

	localparam logic signed [ROT_W-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [ANG_W-1:0] QUARTER  = 34'sd1073741824;
	localparam logic signed [ANG_W-1:0] HALF     = 34'sd2147483648;
	localparam logic signed [32:0]      ONE_Q30  = 33'sd1073741824;
	localparam logic signed [63:0]      ONE_Q60  = 64'sd1152921504606846976;
	localparam logic signed [63:0]      RND_Q30  = 64'sd536870912;

	localparam logic [2:0] ADDR_LATITUDE = 3'd0;

	localparam logic [31:0] ATAN_TAB [0:39] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0,
		32'd0,         32'd0,         32'd0,         32'd0,
		32'd0,         32'd0,         32'd0,         32'd0
	};

	function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] p;
		p = a * b + RND_Q30;
		return p[61:30];
	endfunction

endpackage

@@ rtl/equatorial_to_horizontal_coords.sv @@
// Converts a target's right ascension and declination, with the local sidereal
// time, into altitude and azimuth for the observer latitude held in the
// register at byte address 0. One word is taken in every cycle while the input
// is not stalled, and each word gives exactly one result. The pipeline is made of
// the input register, the 24-step sine and cosine rotation with its load
// stage, a sign stage, two multiply stages, a sum and clamp stage, the 31-step
// square root with its load stage, the 24-step arctangent vectoring with its
// load stage and the output register, each step one register stage.
// A stall on the result side holds the whole pipeline, and the input is then
// stalled in the same cycle.
module equatorial_to_horizontal_coords import eqhor_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               target_valid,
	output logic               target_stall,
	input  logic [31:0]        right_ascension,
	input  logic signed [31:0] declination,
	input  logic [31:0]        sidereal_time,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] altitude,
	output logic [31:0]        azimuth
);

	logic        adv;
	logic [31:0] latitude_q;

	logic        v_s1;
	logic [31:0] ang_s1 [0:2];

	logic                    rv_s  [0:CORDIC_STAGES];
	logic signed [ROT_W-1:0] rx_s  [0:CORDIC_STAGES][0:2];
	logic signed [ROT_W-1:0] ry_s  [0:CORDIC_STAGES][0:2];
	logic signed [ANG_W-1:0] rz_s  [0:CORDIC_STAGES][0:2];
	logic                    rn_s  [0:CORDIC_STAGES][0:2];
	logic signed [ANG_W-1:0] red_z [0:2];
	logic                    red_n [0:2];

	logic               v_s2;
	logic signed [31:0] c_s2 [0:2];
	logic signed [31:0] s_s2 [0:2];

	logic               v_s3;
	logic signed [31:0] cdcl_s3, sdsl_s3, cdsh_s3, sdcl_s3, cdsl_s3, ch_s3;

	logic               v_s4;
	logic signed [31:0] cdclch_s4, cdslch_s4, sdsl_s4, cdsh_s4, sdcl_s4;

	logic               v_s5;
	logic signed [31:0] sa_s5;
	logic signed [33:0] ax_s5, ay_s5;
	logic signed [32:0] sum_c;
	logic signed [63:0] sq_c;

	logic              qv_s  [0:SQRT_STEPS];
	logic [RAD_W-1:0]  qrad_s [0:SQRT_STEPS];
	logic [ROOT_W-1:0] qr_s  [0:SQRT_STEPS];
	logic signed [31:0] qsa_s [0:SQRT_STEPS];
	logic signed [33:0] qax_s [0:SQRT_STEPS];
	logic signed [33:0] qay_s [0:SQRT_STEPS];

	logic                    vv_s [0:CORDIC_STAGES];
	logic signed [VEC_W-1:0] vx_s [0:CORDIC_STAGES][0:1];
	logic signed [VEC_W-1:0] vy_s [0:CORDIC_STAGES][0:1];
	logic signed [ANG_W-1:0] vz_s [0:CORDIC_STAGES][0:1];
	logic                    vzr_s [0:CORDIC_STAGES][0:1];
	logic signed [VEC_W-1:0] pre_x [0:1];
	logic signed [VEC_W-1:0] pre_y [0:1];

	logic               v_s7;
	logic signed [31:0] alt_s7;
	logic [31:0]        az_s7;
	logic signed [ANG_W-1:0] alt_c;

	assign pready       = 1'b1;
	assign prdata       = (paddr == ADDR_LATITUDE) ? latitude_q : 32'd0;
	assign adv          = !(v_s7 && result_stall);
	assign target_stall = v_s7 && result_stall;
	assign result_valid = v_s7;
	assign altitude     = alt_s7;
	assign azimuth      = az_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latitude_q <= 32'd0;
		end else if (psel && penable && pwrite && paddr == ADDR_LATITUDE) begin
			latitude_q <= pwdata;
		end
	end

	// Input stage: hour angle wraps for free in one turn.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= target_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s1[0] <= declination;
			ang_s1[1] <= latitude_q;
			ang_s1[2] <= sidereal_time - right_ascension;
		end
	end

	// Fold each angle into the right half plane.
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			red_z[l] = {{2{ang_s1[l][31]}}, ang_s1[l]};
			red_n[l] = 1'b0;
			if (red_z[l] > QUARTER) begin
				red_z[l] = red_z[l] - HALF;
				red_n[l] = 1'b1;
			end else if (red_z[l] < -QUARTER) begin
				red_z[l] = red_z[l] + HALF;
				red_n[l] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s[0] <= 1'b0;
		end else if (adv) begin
			rv_s[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				rx_s[0][l] <= GAIN_Q30;
				ry_s[0][l] <= '0;
				rz_s[0][l] <= red_z[l];
				rn_s[0][l] <= red_n[l];
			end
		end
	end

	for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_s[gi+1] <= 1'b0;
			end else if (adv) begin
				rv_s[gi+1] <= rv_s[gi];
			end
		end

		for (genvar gl = 0; gl < 3; gl++) begin : g_lane
			logic signed [ANG_W-1:0] step;
			assign step = $signed({2'b00, ATAN_TAB[gi]});

			always_ff @(posedge clk) begin
				if (adv) begin
					rn_s[gi+1][gl] <= rn_s[gi][gl];
					if (!rz_s[gi][gl][ANG_W-1]) begin
						rx_s[gi+1][gl] <= rx_s[gi][gl] - (ry_s[gi][gl] >>> gi);
						ry_s[gi+1][gl] <= ry_s[gi][gl] + (rx_s[gi][gl] >>> gi);
						rz_s[gi+1][gl] <= rz_s[gi][gl] - step;
					end else begin
						rx_s[gi+1][gl] <= rx_s[gi][gl] + (ry_s[gi][gl] >>> gi);
						ry_s[gi+1][gl] <= ry_s[gi][gl] - (rx_s[gi][gl] >>> gi);
						rz_s[gi+1][gl] <= rz_s[gi][gl] + step;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s2 <= rv_s[CORDIC_STAGES];
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign sum_c = {sdsl_s4[31], sdsl_s4} + {cdclch_s4[31], cdclch_s4};
	assign sq_c  = sa_s5 * sa_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 3; l++) begin
				c_s2[l] <= rn_s[CORDIC_STAGES][l] ? 32'(-rx_s[CORDIC_STAGES][l])
					: 32'(rx_s[CORDIC_STAGES][l]);
				s_s2[l] <= rn_s[CORDIC_STAGES][l] ? 32'(-ry_s[CORDIC_STAGES][l])
					: 32'(ry_s[CORDIC_STAGES][l]);
			end

			cdcl_s3 <= mulq(c_s2[0], c_s2[1]);
			sdsl_s3 <= mulq(s_s2[0], s_s2[1]);
			cdsh_s3 <= mulq(c_s2[0], s_s2[2]);
			sdcl_s3 <= mulq(s_s2[0], c_s2[1]);
			cdsl_s3 <= mulq(c_s2[0], s_s2[1]);
			ch_s3   <= c_s2[2];

			cdclch_s4 <= mulq(cdcl_s3, ch_s3);
			cdslch_s4 <= mulq(cdsl_s3, ch_s3);
			sdsl_s4   <= sdsl_s3;
			cdsh_s4   <= cdsh_s3;
			sdcl_s4   <= sdcl_s3;

			if (sum_c > ONE_Q30) begin
				sa_s5 <= 32'(ONE_Q30);
			end else if (sum_c < -ONE_Q30) begin
				sa_s5 <= 32'(-ONE_Q30);
			end else begin
				sa_s5 <= sum_c[31:0];
			end
			ay_s5 <= -{{2{cdsh_s4[31]}}, cdsh_s4};
			ax_s5 <= {{2{sdcl_s4[31]}}, sdcl_s4} - {{2{cdslch_s4[31]}}, cdslch_s4};
		end
	end

	// Square root of one minus the squared sine, one result bit per stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s[0] <= 1'b0;
		end else if (adv) begin
			qv_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qrad_s[0] <= RAD_W'(ONE_Q60 - sq_c);
			qr_s[0]   <= '0;
			qsa_s[0]  <= sa_s5;
			qax_s[0]  <= ax_s5;
			qay_s[0]  <= ay_s5;
		end
	end

	for (genvar gk = 0; gk < SQRT_STEPS; gk++) begin : g_sqrt
		localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (60 - 2 * gk);
		logic [ROOT_W-1:0] trial;

		assign trial = qr_s[gk] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				qv_s[gk+1] <= 1'b0;
			end else if (adv) begin
				qv_s[gk+1] <= qv_s[gk];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if ({2'b00, qrad_s[gk]} >= trial) begin
					qrad_s[gk+1] <= qrad_s[gk] - trial[RAD_W-1:0];
					qr_s[gk+1]   <= (qr_s[gk] >> 1) + BIT;
				end else begin
					qrad_s[gk+1] <= qrad_s[gk];
					qr_s[gk+1]   <= qr_s[gk] >> 1;
				end
				qsa_s[gk+1] <= qsa_s[gk];
				qax_s[gk+1] <= qax_s[gk];
				qay_s[gk+1] <= qay_s[gk];
			end
		end
	end

	// Arctangent by vectoring: lane 0 gives altitude, lane 1 azimuth.
	assign pre_x[0] = $signed({4'b0000, qr_s[SQRT_STEPS][31:0]});
	assign pre_y[0] = {{4{qsa_s[SQRT_STEPS][31]}}, qsa_s[SQRT_STEPS]};
	assign pre_x[1] = {{2{qax_s[SQRT_STEPS][33]}}, qax_s[SQRT_STEPS]};
	assign pre_y[1] = {{2{qay_s[SQRT_STEPS][33]}}, qay_s[SQRT_STEPS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vv_s[0] <= 1'b0;
		end else if (adv) begin
			vv_s[0] <= qv_s[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				vzr_s[0][l] <= (pre_x[l] == '0) && (pre_y[l] == '0);
				if (pre_x[l][VEC_W-1]) begin
					vx_s[0][l] <= -pre_x[l];
					vy_s[0][l] <= -pre_y[l];
					vz_s[0][l] <= HALF;
				end else begin
					vx_s[0][l] <= pre_x[l];
					vy_s[0][l] <= pre_y[l];
					vz_s[0][l] <= '0;
				end
			end
		end
	end

	for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_vec
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vv_s[gi+1] <= 1'b0;
			end else if (adv) begin
				vv_s[gi+1] <= vv_s[gi];
			end
		end

		for (genvar gl = 0; gl < 2; gl++) begin : g_lane
			logic signed [ANG_W-1:0] step;
			assign step = $signed({2'b00, ATAN_TAB[gi]});

			always_ff @(posedge clk) begin
				if (adv) begin
					vzr_s[gi+1][gl] <= vzr_s[gi][gl];
					if (vy_s[gi][gl] > 0) begin
						vx_s[gi+1][gl] <= vx_s[gi][gl] + (vy_s[gi][gl] >>> gi);
						vy_s[gi+1][gl] <= vy_s[gi][gl] - (vx_s[gi][gl] >>> gi);
						vz_s[gi+1][gl] <= vz_s[gi][gl] + step;
					end else begin
						vx_s[gi+1][gl] <= vx_s[gi][gl] - (vy_s[gi][gl] >>> gi);
						vy_s[gi+1][gl] <= vy_s[gi][gl] + (vx_s[gi][gl] >>> gi);
						vz_s[gi+1][gl] <= vz_s[gi][gl] - step;
					end
				end
			end
		end
	end

	always_comb begin
		alt_c = vzr_s[CORDIC_STAGES][0] ? '0 : vz_s[CORDIC_STAGES][0];
		if (alt_c > QUARTER) begin
			alt_c = QUARTER;
		end else if (alt_c < -QUARTER) begin
			alt_c = -QUARTER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= vv_s[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			alt_s7 <= alt_c[31:0];
			az_s7  <= vzr_s[CORDIC_STAGES][1] ? 32'd0 : vz_s[CORDIC_STAGES][1][31:0];
		end
	end

endmodule
